@@ hw/rtl/bclpd_pkg.sv @@
package bclpd_pkg;

   // Latched event codes shown on the result channel.
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_SINGLE  = 3'd1,
      EV_DOUBLE  = 3'd2,
      EV_LONG    = 3'd3,
      EV_REPEAT  = 3'd4,
      EV_RELEASE = 3'd5
   } event_type;

   // Item kinds on the request channel.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Raw pin is active low.
   localparam logic PIN_PRESSED = 1'b0;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DOUBLE_CLICK = 2'd2;

   // Register reset values.
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd20;
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;

   // Hold counter saturation point.
   localparam logic [15:0] HOLD_MAX = 16'hFFFF;

   // Repeats fire past the long-press count at multiples of this period.
   localparam int REPEAT_PERIOD = 100;
   localparam int PHASE_W = $clog2(REPEAT_PERIOD);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(REPEAT_PERIOD - 1);

   typedef struct packed {
      logic kind;
      logic pin_sample;
   } req_data_type;

   typedef struct packed {
      event_type event_code;
      logic      is_pressed;
   } rsp_data_type;

endpackage

@@ hw/rtl/button_click_long_press_detector_unit.sv @@
// The response to an accepted request beat appears in the next cycle.
// Throughput: one request beat per cycle as long as the single response
// register can take a new result: when empty or drained in that cycle.
// Reset (synchronous, active high) returns the configuration registers to
// their defaults, clears all counters, the held flag and the latched event,
// and empties the response register.
module button_click_long_press_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bclpd_pkg::req_data_type         req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bclpd_pkg::rsp_data_type         rsp_data,
   input  logic                            csr_wr_en,
   input  logic [bclpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bclpd_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import bclpd_pkg::*;

   logic [7:0]         debounce_ticks_ff;
   logic [15:0]        long_press_ticks_ff;
   logic [15:0]        double_click_window_ff;

   logic               held_ff, held_in;
   logic [7:0]         bounce_count_ff, bounce_count_in;
   logic [15:0]        hold_ticks_ff, hold_ticks_in;
   logic [PHASE_W-1:0] rep_phase_ff, rep_phase_in;
   logic [1:0]         clicks_seen_ff, clicks_seen_in;
   logic [15:0]        window_left_ff, window_left_in;
   event_type          latched_event_ff, latched_event_in;

   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   logic               req_fire;
   logic [7:0]         bounce_inc;
   logic [15:0]        hold_inc;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign bounce_inc = bounce_count_ff + 8'd1;
   assign hold_inc   = hold_ticks_ff + 16'd1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff      <= DEBOUNCE_RESET;
         long_press_ticks_ff    <= LONG_PRESS_RESET;
         double_click_window_ff <= DOUBLE_CLICK_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_DEBOUNCE:     debounce_ticks_ff      <= csr_wr_data[7:0];
            CSR_LONG_PRESS:   long_press_ticks_ff    <= csr_wr_data;
            CSR_DOUBLE_CLICK: double_click_window_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Next state for a tick: debounce, hold tracking, click decode, then
   // the double-click window countdown on the updated state.
   always_comb begin
      held_in          = held_ff;
      bounce_count_in  = bounce_count_ff;
      hold_ticks_in    = hold_ticks_ff;
      rep_phase_in     = rep_phase_ff;
      clicks_seen_in   = clicks_seen_ff;
      window_left_in   = window_left_ff;
      latched_event_in = latched_event_ff;

      if (req_data.kind == KIND_CLEAR) begin
         latched_event_in = EV_NONE;
      end else begin
         if (req_data.pin_sample == PIN_PRESSED) begin
            if (!held_ff) begin
               // Counting toward an accepted press.
               bounce_count_in = bounce_inc;
               if (bounce_inc >= debounce_ticks_ff) begin
                  held_in         = 1'b1;
                  hold_ticks_in   = '0;
                  rep_phase_in    = '0;
                  bounce_count_in = '0;
               end
            end else if (hold_ticks_ff != HOLD_MAX) begin
               // Held: advance the hold count and its repeat phase.
               hold_ticks_in = hold_inc;
               rep_phase_in  = (rep_phase_ff == PHASE_LAST) ? '0
                                                            : rep_phase_ff + 1'b1;
               if (hold_inc == long_press_ticks_ff) begin
                  latched_event_in = EV_LONG;
                  clicks_seen_in   = '0;
                  window_left_in   = '0;
               end else if (hold_inc > long_press_ticks_ff &&
                            rep_phase_ff == PHASE_LAST) begin
                  latched_event_in = EV_REPEAT;
               end
            end
         end else begin
            if (!held_ff) begin
               bounce_count_in = '0;
            end else begin
               // Counting toward an accepted release.
               bounce_count_in = bounce_inc;
               if (bounce_inc >= debounce_ticks_ff) begin
                  held_in         = 1'b0;
                  bounce_count_in = '0;
                  if (hold_ticks_ff < long_press_ticks_ff) begin
                     clicks_seen_in = clicks_seen_ff + 2'd1;
                     if (clicks_seen_in == 2'd1) begin
                        latched_event_in = EV_SINGLE;
                        window_left_in   = double_click_window_ff;
                     end else if (clicks_seen_in >= 2'd2) begin
                        latched_event_in = EV_DOUBLE;
                        window_left_in   = '0;
                        clicks_seen_in   = '0;
                     end
                  end else begin
                     latched_event_in = EV_RELEASE;
                     clicks_seen_in   = '0;
                     window_left_in   = '0;
                  end
               end
            end
         end

         // Window countdown; expiry after a lone click re-raises single click.
         if (window_left_in != 16'd0) begin
            window_left_in = window_left_in - 16'd1;
            if (window_left_in == 16'd0) begin
               if (clicks_seen_in == 2'd1) begin
                  latched_event_in = EV_SINGLE;
                  clicks_seen_in   = '0;
               end else if (clicks_seen_in >= 2'd2) begin
                  clicks_seen_in = '0;
               end
            end
         end
      end
   end

   // State registers move only on an accepted request beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff          <= 1'b0;
         bounce_count_ff  <= '0;
         hold_ticks_ff    <= '0;
         rep_phase_ff     <= '0;
         clicks_seen_ff   <= '0;
         window_left_ff   <= '0;
         latched_event_ff <= EV_NONE;
      end else if (req_fire) begin
         held_ff          <= held_in;
         bounce_count_ff  <= bounce_count_in;
         hold_ticks_ff    <= hold_ticks_in;
         rep_phase_ff     <= rep_phase_in;
         clicks_seen_ff   <= clicks_seen_in;
         window_left_ff   <= window_left_in;
         latched_event_ff <= latched_event_in;
      end
   end

   // Response register: filled on each accepted beat, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff.event_code <= latched_event_in;
         rsp_data_ff.is_pressed <= held_in;
      end
   end

endmodule

@@ hw/rtl/bclpd_checker.sv @@
module bclpd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input bclpd_pkg::req_data_type req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input bclpd_pkg::rsp_data_type rsp_data
);
   import bclpd_pkg::*;

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // The response register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request beat yields a response in the next cycle.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat produced no response");

   // A clear beat always reports no event.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_CLEAR
      |=> rsp_data.event_code == EV_NONE)
      else $error("clear beat did not clear the event");

   // A full, stalled response register blocks new requests.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while response stalled");

endmodule

bind button_click_long_press_detector_unit bclpd_checker u_bclpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
